// File: design/convolution_2d_border_modes_assert.svh
// Assertion macros for the 2D convolution block.
`ifndef CONVOLUTION_2D_BORDER_MODES_ASSERT_SVH
`define CONVOLUTION_2D_BORDER_MODES_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check with asynchronous active-low reset disable.
`define C2DBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define C2DBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define C2DBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2DBM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/c2dbm_pkg.sv
package c2dbm_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_KERNEL_DEF = 9;

  // signed width for tap coordinates before and after border remap
  localparam int CW = 12;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 9;

  localparam logic [CFG_IW-1:0] REG_BORDER_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_KERNEL_WIDTH  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_KERNEL_HEIGHT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_OUTPUT_SHIFT  = 3'd5;

  localparam logic [1:0] FUNC_LOAD_COEF  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_PIXEL = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

  localparam logic [1:0] BM_ZERO   = 2'd0;
  localparam logic [1:0] BM_CLAMP  = 2'd1;
  localparam logic [1:0] BM_MIRROR = 2'd2;
  localparam logic [1:0] BM_WRAP   = 2'd3;

  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = 24'sh800000;

  typedef struct packed {
    logic [1:0] border_mode;
    logic [8:0] image_width;
    logic [8:0] image_height;
    logic [3:0] kernel_width;
    logic [3:0] kernel_height;
    logic [3:0] output_shift;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic ok;
    logic last;
  } tap_ctl_t;

  typedef struct packed {
    logic       ok;
    logic [8:0] coord;
  } coord_t;

  // Border remap of one axis; ok low means the tap adds nothing.
  function automatic coord_t resolve(input logic signed [CW-1:0] t,
                                     input logic [8:0] size,
                                     input logic [1:0] mode);
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] r;
    coord_t               res;
    s      = $signed(CW'(size));
    r      = t;
    res.ok = 1'b1;
    if (t < 0 || t >= s) begin
      case (mode)
        BM_CLAMP:  r = (t < 0) ? '0 : s - CW'(1);
        BM_MIRROR: r = (t < 0) ? -t : (s <<< 1) - CW'(2) - t;
        BM_WRAP:   r = (t < 0) ? s + t : t - s;
        default:   res.ok = 1'b0;
      endcase
      if (r < 0 || r >= s) begin
        res.ok = 1'b0;
      end
    end
    res.coord = r[8:0];
    return res;
  endfunction

endpackage

// File: design/convolution_2d_border_modes.sv
// Load requests (coefficient or pixel) are accepted whenever the block is idle.
// A compute request walks kw*kh taps, one tap per cycle through the shared
// multiply-accumulate unit; the sum is shifted, saturated and sent on m_axis.
// The input side is ready again once the result of an accepted compute
// moves into the output register; a stalled result delays it.
// Reset clears control and configuration (0,256,256,3,3,8); stores stay undefined.
`include "convolution_2d_border_modes_assert.svh"

module convolution_2d_border_modes #(
  parameter int MAX_WIDTH  = c2dbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c2dbm_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_KERNEL = c2dbm_pkg::MAX_KERNEL_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [c2dbm_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [c2dbm_pkg::CFG_DW-1:0] cfg_data_i,
  // request stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // pos_x[7:0], pos_y[15:8], data[31:16]
  input  logic [1:0]                   s_axis_tuser,  // func[1:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // value[23:0]
  output logic [0:0]                   m_axis_tuser   // saturated[0]
);
  import c2dbm_pkg::*;

  localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int KDEPTH    = MAX_KERNEL * MAX_KERNEL;
  localparam int CAW       = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic        state_q, state_d;
  cfg_t        cfg_q;

  logic [1:0]  func;
  logic [7:0]  pos_x, pos_y;
  logic [15:0] data;
  logic        s_hs, start;

  tap_ctl_t          tap_ctl;
  logic [IMG_AW-1:0] img_addr;
  logic [CAW-1:0]    coef_addr;

  // tap stores
  logic [7:0]  img_mem  [IMG_DEPTH];
  logic [15:0] coef_mem [KDEPTH];
  tap_ctl_t    rd_ctl_q;
  logic [7:0]  pix_q;
  logic [15:0] coef_q;

  logic        res_valid, res_sat, take;
  logic [23:0] res_value;

  logic        o_valid_q;
  logic [23:0] o_value_q;
  logic        o_sat_q;

  assign func  = s_axis_tuser;
  assign pos_x = s_axis_tdata[7:0];
  assign pos_y = s_axis_tdata[15:8];
  assign data  = s_axis_tdata[31:16];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_hs          = s_axis_tvalid & s_axis_tready;
  assign start         = s_hs & (func == FUNC_COMPUTE);

  // result moves to the output register once that is free
  assign take = res_valid & (~o_valid_q | m_axis_tready);

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.border_mode   <= BM_ZERO;
      cfg_q.image_width   <= 9'd256;
      cfg_q.image_height  <= 9'd256;
      cfg_q.kernel_width  <= 4'd3;
      cfg_q.kernel_height <= 4'd3;
      cfg_q.output_shift  <= 4'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BORDER_MODE:   cfg_q.border_mode   <= cfg_data_i[1:0];
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[8:0];
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[8:0];
        REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data_i[3:0];
        REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data_i[3:0];
        REG_OUTPUT_SHIFT:  cfg_q.output_shift  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_BUSY;
      ST_BUSY: if (take)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- tap walker ----------------
  c2dbm_tap_walk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL),
    .IMG_AW     (IMG_AW),
    .CAW        (CAW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .pos_x_i     (pos_x),
    .pos_y_i     (pos_y),
    .cfg_i       (cfg_q),
    .tap_ctl_o   (tap_ctl),
    .img_addr_o  (img_addr),
    .coef_addr_o (coef_addr)
  );

  // ---------------- stores ----------------
  // loads only land while idle, so writes never meet a tap read
  always_ff @(posedge clk_i) begin
    if (s_hs && func == FUNC_LOAD_PIXEL && 32'(pos_x) < MAX_WIDTH &&
        32'(pos_y) < MAX_HEIGHT) begin
      img_mem[IMG_AW'(32'(pos_y) * MAX_WIDTH + 32'(pos_x))] <= data[7:0];
    end
    pix_q <= img_mem[img_addr];
  end

  always_ff @(posedge clk_i) begin
    if (s_hs && func == FUNC_LOAD_COEF && 32'(pos_x) < MAX_KERNEL &&
        32'(pos_y) < MAX_KERNEL) begin
      coef_mem[CAW'(32'(pos_y) * MAX_KERNEL + 32'(pos_x))] <= data;
    end
    coef_q <= coef_mem[coef_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ctl_q <= '0;
    end else begin
      rd_ctl_q <= tap_ctl;
    end
  end

  // ---------------- multiply-accumulate ----------------
  c2dbm_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start),
    .rd_ctl_i    (rd_ctl_q),
    .coef_i      (coef_q),
    .pix_i       (pix_q),
    .shift_i     (cfg_q.output_shift),
    .take_i      (take),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_sat_o   (res_sat)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (take) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      o_value_q <= res_value;
      o_sat_q   <= res_sat;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_value_q;
  assign m_axis_tuser  = o_sat_q;

  // ---------------- checks ----------------
  `C2DBM_ASSERT(a_tap_only_busy, clk_i, rst_ni, tap_ctl.valid |-> (state_q == ST_BUSY), "tap issued while idle")
  `C2DBM_ASSERT(a_res_only_busy, clk_i, rst_ni, res_valid |-> (state_q == ST_BUSY), "result with no compute")
  `C2DBM_ASSERT(a_start_taps, clk_i, rst_ni, start |=> ##1 tap_ctl.valid, "compute issued no tap")
  `C2DBM_ASSERT(a_rd_follows_tap, clk_i, rst_ni, tap_ctl.valid |=> rd_ctl_q.valid, "tap read lost")

endmodule

// File: design/c2dbm_tap_walk.sv
module c2dbm_tap_walk #(
  parameter int MAX_WIDTH  = c2dbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c2dbm_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_KERNEL = c2dbm_pkg::MAX_KERNEL_DEF,
  parameter int IMG_AW     = 16,
  parameter int CAW        = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [7:0]            pos_x_i,
  input  logic [7:0]            pos_y_i,
  input  c2dbm_pkg::cfg_t       cfg_i,
  output c2dbm_pkg::tap_ctl_t   tap_ctl_o,
  output logic [IMG_AW-1:0]     img_addr_o,
  output logic [CAW-1:0]        coef_addr_o
);
  import c2dbm_pkg::*;

  localparam int KIW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CMPW = (KIW > 4) ? KIW : 4;

  logic            run_q, run_d;
  logic [KIW-1:0]  i_q, i_d, j_q, j_d;
  logic [7:0]      px_q, py_q;
  logic [8:0]      w_eff, h_eff;
  logic [3:0]      kw_eff, kh_eff;
  logic            i_end, j_end;
  logic signed [CW-1:0] tx_raw, ty_raw;
  coord_t          tx, ty;
  tap_ctl_t        ctl_q, ctl_d;
  logic [IMG_AW-1:0] img_addr_q;
  logic [CAW-1:0]    coef_addr_q;

  always_comb begin
    w_eff  = (cfg_i.image_width == '0) ? 9'd1 :
             (32'(cfg_i.image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg_i.image_width;
    h_eff  = (cfg_i.image_height == '0) ? 9'd1 :
             (32'(cfg_i.image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : cfg_i.image_height;
    kw_eff = (cfg_i.kernel_width == '0) ? 4'd1 :
             (32'(cfg_i.kernel_width) > MAX_KERNEL) ? 4'(MAX_KERNEL) : cfg_i.kernel_width;
    kh_eff = (cfg_i.kernel_height == '0) ? 4'd1 :
             (32'(cfg_i.kernel_height) > MAX_KERNEL) ? 4'(MAX_KERNEL) : cfg_i.kernel_height;
  end

  assign i_end = (CMPW'(i_q) == CMPW'(kw_eff - 4'd1));
  assign j_end = (CMPW'(j_q) == CMPW'(kh_eff - 4'd1));

  // tap position relative to the kernel centre
  assign tx_raw = $signed(CW'(px_q) + CW'(i_q) - CW'(kw_eff >> 1));
  assign ty_raw = $signed(CW'(py_q) + CW'(j_q) - CW'(kh_eff >> 1));
  assign tx     = resolve(tx_raw, w_eff, cfg_i.border_mode);
  assign ty     = resolve(ty_raw, h_eff, cfg_i.border_mode);

  always_comb begin
    run_d       = run_q;
    i_d         = i_q;
    j_d         = j_q;
    ctl_d.valid = run_q;
    ctl_d.ok    = tx.ok & ty.ok;
    ctl_d.last  = i_end & j_end;
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      j_d   = '0;
    end else if (run_q) begin
      if (i_end) begin
        i_d = '0;
        if (j_end) begin
          run_d = 1'b0;
        end else begin
          j_d = j_q + KIW'(1);
        end
      end else begin
        i_d = i_q + KIW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      i_q   <= '0;
      j_q   <= '0;
      ctl_q <= '0;
    end else begin
      run_q <= run_d;
      i_q   <= i_d;
      j_q   <= j_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
    img_addr_q  <= IMG_AW'(32'(ty.coord) * MAX_WIDTH + 32'(tx.coord));
    coef_addr_q <= CAW'(32'(j_q) * MAX_KERNEL + 32'(i_q));
  end

  assign tap_ctl_o   = ctl_q;
  assign img_addr_o  = img_addr_q;
  assign coef_addr_o = coef_addr_q;

endmodule

// File: design/c2dbm_mac.sv
module c2dbm_mac #(
  parameter int MAX_KERNEL = c2dbm_pkg::MAX_KERNEL_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  c2dbm_pkg::tap_ctl_t rd_ctl_i,
  input  logic [15:0]         coef_i,
  input  logic [7:0]          pix_i,
  input  logic [3:0]          shift_i,
  input  logic                take_i,
  output logic                res_valid_o,
  output logic [23:0]         res_value_o,
  output logic                res_sat_o
);
  import c2dbm_pkg::*;

  localparam int ACC_W = 25 + $clog2(MAX_KERNEL * MAX_KERNEL);

  tap_ctl_t                 p_ctl_q;
  logic signed [23:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  sh_q;
  logic                     fin_q, sh_vld_q, res_valid_q;
  logic [23:0]              res_value_q;
  logic                     res_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctl_q     <= '0;
      fin_q       <= 1'b0;
      sh_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      p_ctl_q  <= rd_ctl_i;
      fin_q    <= p_ctl_q.valid & p_ctl_q.last;
      sh_vld_q <= fin_q;
      if (sh_vld_q) begin
        res_valid_q <= 1'b1;
      end else if (take_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // a tap whose border remap fails (ok low) adds zero
    prod_q <= rd_ctl_i.ok ? 24'($signed(coef_i)) * 24'($signed({1'b0, pix_i})) : '0;
    if (clear_i) begin
      acc_q <= '0;
    end else if (p_ctl_q.valid) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    sh_q <= acc_q >>> shift_i;
    if (sh_vld_q) begin
      if (sh_q > ACC_W'(VAL_MAX)) begin
        res_value_q <= VAL_MAX;
        res_sat_q   <= 1'b1;
      end else if (sh_q < ACC_W'(VAL_MIN)) begin
        res_value_q <= VAL_MIN;
        res_sat_q   <= 1'b1;
      end else begin
        res_value_q <= sh_q[23:0];
        res_sat_q   <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_value_o = res_value_q;
  assign res_sat_o   = res_sat_q;

endmodule
